### sv/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants of the adaptive pendulum controller
// Register indexes, estimate resets, sine constants and the sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none
package apc_pkg;

  localparam int SineTableBits = 10;

  localparam logic [2:0] REG_LAMBDA  = 3'd0;
  localparam logic [2:0] REG_SLIDING = 3'd1;
  localparam logic [2:0] REG_GAIN_I  = 3'd2;
  localparam logic [2:0] REG_GAIN_D  = 3'd3;
  localparam logic [2:0] REG_GAIN_G  = 3'd4;
  localparam logic [2:0] REG_STEP    = 3'd5;

  localparam logic signed [47:0] INERTIA_RESET = 48'sd6442450944;
  localparam logic signed [47:0] DAMPING_RESET = 48'sd858993459;
  localparam logic signed [47:0] GRAVITY_RESET = 48'sd17179869184;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [31:0] HALF_PI_Q31    = 32'd3373259426;
  localparam logic [30:0] ONE_Q30        = 31'd1073741824;

  // Sequencer states: one shared multiply per state, with steps that need no multiply in between
  typedef enum logic [4:0] {
    ST_IDLE, ST_ERR,
    ST_DQR, ST_DDQR, ST_SIG,
    ST_PH, ST_X, ST_X2, ST_T1, ST_T2, ST_T3, ST_Y,
    ST_TAU1, ST_TAU2, ST_TAU3, ST_TAU4,
    ST_G, ST_GS, ST_D, ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

### sv/apc_mul.sv
// ----------------------------------------------------------------------------
// apc_mul: shared signed multiplier
// Forms a full 128 bit signed product of two 64 bit operands from eight
// 32 x 16 bit partial products, accumulated in a register.
// ----------------------------------------------------------------------------
`default_nettype none
module apc_mul
  import apc_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mul_req_t       req,
  output logic                done,
  output logic signed [127:0] prod
);

  logic [63:0] ua, ub;
  logic [127:0] acc;
  logic [4:0] cnt;
  logic busy;
  logic neg;
  logic [31:0] a_word;
  logic [15:0] b_part;
  logic [47:0] pp;
  logic [6:0] sh;

  // operand magnitudes are taken so that unsigned partials suffice
  assign a_word = cnt[3] ? ua[63:32] : ua[31:0];
  assign b_part = ub[16*cnt[1:0] +: 16];
  assign pp = 48'(a_word) * 48'(b_part);
  assign sh = {cnt[3], 5'd0} + {cnt[1:0], 4'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // skip index bit 2: loops a-word (bit3) over four b-digits (bits 1:0)
  always_ff @(posedge clk) begin
    if (req.start) begin
      ua   <= req.a[63] ? 64'(-req.a) : req.a;
      ub   <= req.b[63] ? 64'(-req.b) : req.b;
      neg  <= req.a[63] ^ req.b[63];
      acc  <= '0;
    end else if (busy && !cnt[2]) begin
      acc <= acc + (128'(pp) << sh);
    end
  end

  assign prod = neg ? -$signed(acc) : $signed(acc);

endmodule
`default_nettype wire

### sv/adaptive_pendulum_controller.sv
// Each input runs 22 multiplies on the shared 64x64 multiplier and five steps
// that need no multiply.
// s_tready is low from acceptance until the result is taken on the master
// side, so a new input is taken only after the previous result has left.
// Reset: synchronous, active high; the sequencer, configuration registers and
// estimates return to their defaults, the estimates to 1.5, 0.2 and 4.0.
// ----------------------------------------------------------------------------
// adaptive_pendulum_controller: Slotine-Li adaptive joint controller
// Sequencer over one shared multiplier computing torque, s and updates.
// ----------------------------------------------------------------------------
`default_nettype none
module adaptive_pendulum_controller
  import apc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // angle, rate, target_angle, target_rate, target_accel (low to high)
  input  wire logic [159:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // torque, sliding_error (low to high)
  output logic [63:0]       m_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  state_t state, state_next;
  logic [30:0] lambda_gain, sliding_gain, gain_i, gain_d, gain_g;
  logic [31:0] time_step;
  logic signed [47:0] est [3];
  logic signed [31:0] q, dq, qd, dqd, ddqd;
  logic signed [63:0] dqr, ddqr, acc, tmp;
  logic signed [31:0] s, y [3];
  logic [30:0] xr;
  logic [31:0] x2;
  logic [1:0] quad, k;
  logic [30:0] tq;
  logic signed [31:0] torque;
  mul_req_t req;
  logic mdone;
  logic signed [127:0] prod;
  logic issued;

  apc_mul u_mul (.clk(clk), .rst(rst), .req(req), .done(mdone), .prod(prod));

  // floor(prod / 2^n) saturated to w bits
  function automatic logic signed [63:0] shsat(input logic signed [127:0] p,
                                               input int n, input int w);
    logic signed [127:0] r;
    logic signed [127:0] hi;
    begin
      r  = p >>> n;
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      if (r > hi) shsat = 64'(hi);
      else if (r < -hi - 128'sd1) shsat = 64'(-hi - 128'sd1);
      else shsat = 64'(r);
    end
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [65:0] v,
                                               input int w);
    logic signed [65:0] hi;
    begin
      hi = (66'sd1 <<< (w - 1)) - 66'sd1;
      if (v > hi) sat64 = 64'(hi);
      else if (v < -hi - 66'sd1) sat64 = 64'(-hi - 66'sd1);
      else sat64 = 64'(v);
    end
  endfunction

  // divide Q2.30 term by small constant via reciprocal with one correction
  function automatic logic [30:0] divc(input logic [31:0] v, input logic [6:0] d);
    logic [63:0] qe;
    logic [31:0] rem;
    begin
      qe = (64'(v) * (64'(33'h1_0000_0000) / 64'(d))) >> 32;
      rem = v - 32'(qe) * 32'(d);
      if (rem >= 32'(d)) qe = qe + 64'd1;
      divc = 31'(qe);
    end
  endfunction

  // Next state: step through the computation, at most one multiply per state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_ERR;
      ST_ERR:  state_next = ST_DQR;
      ST_SIG:  state_next = ST_PH;
      ST_OUT:  if (m_tready) state_next = ST_IDLE;
      ST_UPD:  state_next = (k == 2'd2) ? ST_OUT : ST_G;
      default: if (mdone) begin
        unique case (state)
          ST_DQR:  state_next = ST_DDQR;
          ST_DDQR: state_next = ST_SIG;
          ST_PH:   state_next = ST_X;
          ST_X:    state_next = ST_X2;
          ST_X2:   state_next = ST_T1;
          ST_T1:   state_next = ST_T2;
          ST_T2:   state_next = ST_T3;
          ST_T3:   state_next = ST_Y;
          ST_Y:    state_next = ST_TAU1;
          ST_TAU1: state_next = ST_TAU2;
          ST_TAU2: state_next = ST_TAU3;
          ST_TAU3: state_next = ST_TAU4;
          ST_TAU4: state_next = ST_G;
          ST_G:    state_next = ST_GS;
          ST_GS:   state_next = ST_D;
          default: state_next = ST_UPD;
        endcase
      end
    endcase
  end

  // Outputs: multiplier operands per state
  always_comb begin
    req.a = '0;
    req.b = '0;
    unique case (state)
      ST_DQR:  begin req.a = 64'(lambda_gain); req.b = 64'(q) - 64'(qd); end
      ST_DDQR: begin req.a = 64'(lambda_gain); req.b = 64'(dq) - 64'(dqd); end
      ST_PH:   begin req.a = 64'(q); req.b = 64'(INV_TWO_PI_Q32); end
      ST_X:    begin req.a = 64'(xr); req.b = 64'(HALF_PI_Q31); end
      ST_X2:   begin req.a = 64'(tmp[31:0]); req.b = 64'(tmp[31:0]); end
      ST_T1, ST_T2, ST_T3: begin req.a = 64'(x2); req.b = 64'(tq); end
      ST_Y:    begin req.a = 64'(tmp[31:0]); req.b = 64'(tq); end
      ST_TAU1: begin req.a = 64'(y[0]); req.b = 64'(est[0]); end
      ST_TAU2: begin req.a = 64'(y[1]); req.b = 64'(est[1]); end
      ST_TAU3: begin req.a = 64'(y[2]); req.b = 64'(est[2]); end
      ST_TAU4: begin req.a = 64'(sliding_gain); req.b = 64'(s); end
      ST_G: begin
        req.a = (k == 2'd0) ? 64'(gain_i) : (k == 2'd1) ? 64'(gain_d) : 64'(gain_g);
        req.b = 64'(y[k]);
      end
      ST_GS:   begin req.a = tmp; req.b = 64'(s); end
      ST_D:    begin req.a = tmp; req.b = 64'(time_step); end
      default: ;
    endcase
    req.start = !issued && !(state == ST_IDLE || state == ST_ERR || state == ST_SIG ||
                             state == ST_UPD || state == ST_OUT);
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {s, torque};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issued <= 1'b0;
      lambda_gain <= 31'd327680;
      sliding_gain <= 31'd655360;
      gain_i <= 31'd327680;
      gain_d <= 31'd327680;
      gain_g <= 31'd327680;
      time_step <= 32'd4294967;
      est[0] <= INERTIA_RESET;
      est[1] <= DAMPING_RESET;
      est[2] <= GRAVITY_RESET;
      k <= '0;
    end else begin
      state <= state_next;
      issued <= mdone ? 1'b0 : (issued | req.start);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LAMBDA:  lambda_gain <= cfg_data[30:0];
          REG_SLIDING: sliding_gain <= cfg_data[30:0];
          REG_GAIN_I:  gain_i <= cfg_data[30:0];
          REG_GAIN_D:  gain_d <= cfg_data[30:0];
          REG_GAIN_G:  gain_g <= cfg_data[30:0];
          REG_STEP:    time_step <= cfg_data;
          default: ;
        endcase
      end
      if (state == ST_ERR) k <= '0;
      if (state == ST_UPD) begin
        est[k] <= 48'(sat64(66'(est[k]) - 66'(tmp), 48));
        k <= k + 2'd1;
      end
    end
  end

  // Datapath: capture input and fold each product into the working set
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      q <= s_tdata[31:0]; dq <= s_tdata[63:32]; qd <= s_tdata[95:64];
      dqd <= s_tdata[127:96]; ddqd <= s_tdata[159:128];
    end
    if (state == ST_SIG) begin
      s <= 32'(sat64(66'(dq) - 66'(dqr), 32));
      y[0] <= 32'(sat64(66'(ddqr), 32));
      y[1] <= 32'(sat64(66'(dqr), 32));
    end
    if (mdone) begin
      unique case (state)
        ST_DQR:  dqr <= 64'(dqd) - shsat(prod, 16, 62);
        ST_DDQR: ddqr <= 64'(ddqd) - shsat(prod, 16, 62);
        ST_PH: begin
          quad <= prod[47:46];
          xr <= prod[46]
              ? 31'(ONE_Q30 - 31'({prod[45:16+32-SineTableBits],
                                   {(32-SineTableBits){1'b0}}} & 30'h3FFFFFFF))
              : 31'({prod[45:16+32-SineTableBits],
                     {(32-SineTableBits){1'b0}}} & 30'h3FFFFFFF);
        end
        ST_X:    tmp <= 64'(prod[94:31]);
        ST_X2: begin x2 <= 32'(prod >> 30); tq <= ONE_Q30 - divc(32'(prod >> 30), 7'd72); end
        ST_T1:   tq <= ONE_Q30 - divc(32'(prod >> 30), 7'd42);
        ST_T2:   tq <= ONE_Q30 - divc(32'(prod >> 30), 7'd20);
        ST_T3:   tq <= ONE_Q30 - divc(32'(prod >> 30), 7'd6);
        ST_Y: begin
          if ((prod >> 44) > 128'd65536)
            y[2] <= quad[1] ? -32'sd65536 : 32'sd65536;
          else
            y[2] <= quad[1] ? -$signed(32'(prod >> 44)) : $signed(32'(prod >> 44));
        end
        ST_TAU1: acc <= shsat(prod, 32, 62);
        ST_TAU2: acc <= acc + shsat(prod, 32, 62);
        ST_TAU3: acc <= acc + shsat(prod, 32, 62);
        ST_TAU4: torque <= 32'(sat64(66'(acc) - 66'(shsat(prod, 16, 62)), 32));
        ST_G, ST_GS: tmp <= shsat(prod, 16, 62);
        ST_D:    tmp <= shsat(prod, 16, 48);
        default: ;
      endcase
    end
  end

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    req.start |=> !req.start) else $error("double multiply start");

endmodule
`default_nettype wire

### dv/tb_adaptive_pendulum_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_pendulum_controller: self-checking bench of the adaptive controller
// Drives control ticks through the stream slave port, predicts torque and
// sliding error from a model of the adaptive law with its own estimates, and
// compares every result transfer. Phases vary gains, time step and idling.
// ----------------------------------------------------------------------------
module tb_adaptive_pendulum_controller;
  import apc_pkg::*;

  // Fields from the lowest bit up: angle, rate, target_angle, target_rate,
  // target_accel
  typedef struct packed {
    logic signed [31:0] target_accel;
    logic signed [31:0] target_rate;
    logic signed [31:0] target_angle;
    logic signed [31:0] rate;
    logic signed [31:0] angle;
  } tick_t;

  // Fields from the lowest bit up: torque, sliding_error
  typedef struct packed {
    logic signed [31:0] sliding_error;
    logic signed [31:0] torque;
  } command_t;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int IdleLimit = 20000;

  // Adaptive law predictor and queue of expected commands
  class controller_scoreboard;
    longint lambda_gain, sliding_gain, gain_i, gain_d, gain_g, step_size;
    longint est_i, est_d, est_g;
    command_t expected_q[$];
    int errors, ticks, commands;

    function new();
      lambda_gain = 327680;
      sliding_gain = 655360;
      gain_i = 327680;
      gain_d = 327680;
      gain_g = 327680;
      step_size = 4294967;
      est_i = INERTIA_RESET;
      est_d = DAMPING_RESET;
      est_g = GRAVITY_RESET;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LAMBDA:  lambda_gain = val[30:0];
        REG_SLIDING: sliding_gain = val[30:0];
        REG_GAIN_I:  gain_i = val[30:0];
        REG_GAIN_D:  gain_d = val[30:0];
        REG_GAIN_G:  gain_g = val[30:0];
        REG_STEP:    step_size = {32'd0, val};
        default: ;
      endcase
    endfunction

    function longint clamp(logic signed [127:0] v, int w);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[63:0];
      if (v < lo) return lo[63:0];
      return v[63:0];
    endfunction

    // floor(a*b / 2^n), saturated to w bits
    function longint mul_shift(longint a, longint b, int n, int w);
      logic signed [127:0] pa, pb, p;
      pa = a;
      pb = b;
      p = (pa * pb) >>> n;
      return clamp(p, w);
    endfunction

    function longint sine_q16(logic signed [31:0] ang);
      bit [63:0] a64, prod, r, x, x2, t, y;
      bit [31:0] phase;
      bit [1:0] quad;
      a64 = {{32{ang[31]}}, ang};
      prod = a64 * 64'(INV_TWO_PI_Q32);
      phase = prod[47:16];
      phase &= ~((32'd1 << (32 - SineTableBits)) - 1);
      quad = phase[31:30];
      r = {34'd0, phase[29:0]};
      if (quad[0]) r = 64'(ONE_Q30) - r;
      x = (r * 64'(HALF_PI_Q31)) >> 31;
      x2 = (x * x) >> 30;
      t = 64'(ONE_Q30) - x2 / 72;
      t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 42;
      t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 20;
      t = 64'(ONE_Q30) - ((x2 * t) >> 30) / 6;
      y = ((x * t) >> 30) >> 14;
      if (y > 65536) y = 65536;
      return quad[1] ? -longint'(y) : longint'(y);
    endfunction

    function longint adapt(longint est, longint gain, longint y, longint s);
      longint g, gs, d;
      g = mul_shift(gain, y, 16, 62);
      gs = mul_shift(g, s, 16, 62);
      d = mul_shift(gs, step_size, 16, 48);
      return clamp(est - d, 48);
    endfunction

    // Predict the command of one accepted tick and advance the estimates
    function void note_tick(tick_t tk);
      longint e, de, dqr, ddqr, s, y1, y2, y3;
      logic signed [127:0] sum;
      command_t c;
      e = longint'(tk.angle) - longint'(tk.target_angle);
      de = longint'(tk.rate) - longint'(tk.target_rate);
      dqr = longint'(tk.target_rate) - mul_shift(lambda_gain, e, 16, 62);
      ddqr = longint'(tk.target_accel) - mul_shift(lambda_gain, de, 16, 62);
      s = clamp(longint'(tk.rate) - dqr, 32);
      y1 = clamp(ddqr, 32);
      y2 = clamp(dqr, 32);
      y3 = sine_q16(tk.angle);
      sum = 128'(mul_shift(y1, est_i, 32, 62));
      sum += 128'(mul_shift(y2, est_d, 32, 62));
      sum += 128'(mul_shift(y3, est_g, 32, 62));
      sum -= 128'(mul_shift(sliding_gain, s, 16, 62));
      c.torque = clamp(sum, 32);
      c.sliding_error = s;
      est_i = adapt(est_i, gain_i, y1, s);
      est_d = adapt(est_d, gain_d, y2, s);
      est_g = adapt(est_g, gain_g, y3, s);
      expected_q.push_back(c);
      ticks++;
    endfunction

    function void check_command(command_t got);
      command_t want;
      commands++;
      if (expected_q.size() == 0) begin
        $error("command transfer with no tick pending: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.torque !== want.torque) begin
        $error("torque: expected %0d, got %0d", want.torque, got.torque);
        errors++;
      end
      if (got.sliding_error !== want.sliding_error) begin
        $error("sliding_error: expected %0d, got %0d", want.sliding_error,
               got.sliding_error);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_LAMBDA;
  logic [31:0] cfg_data = '0;

  controller_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  adaptive_pendulum_controller DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check command transfers and drive the receiver, with long hold-offs
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_command(command_t'(m_tdata));
    if (hold_request > 0) begin
      hold_cnt = hold_request;
      hold_request = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("[adaptive_pendulum_controller] ERROR");
      $finish;
    end
  end

  // Pulse the write enable for one cycle, then wait with it low before returning
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // Hold until every expected command has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_tick(tick_t tk);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= tk;
    do @(posedge clk); while (!s_tready);
    sb.note_tick(tk);
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Plausible radians and rates half the time, else full range, zero or extremes
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      4: return 32'd0;
      default: return $urandom_range(0, 1048576) - 524288;
    endcase
  endfunction

  function automatic tick_t random_tick();
    tick_t tk;
    tk.angle = pick_value();
    tk.rate = pick_value();
    tk.target_angle = pick_value();
    tk.target_rate = pick_value();
    tk.target_accel = pick_value();
    return tk;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 20 << 16);
    endcase
  endfunction

  initial begin
    tick_t tk;
    int phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes and quadrant corners of the sine at reset gains
    send_tick('0);
    send_tick({5{32'h7FFF_FFFF}});
    send_tick({5{32'h8000_0000}});
    send_tick({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0003_243F});
    send_tick({32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFC_DBC1});
    send_tick({32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_921F});
    send_tick({32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFE_6DE1});
    send_tick({32'h0, 32'h0, 32'h0, 32'h0, 32'h0006_487F});
    send_tick({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000});
    send_tick({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF});
    drain();

    // Directed: largest gains and time step drive the estimates to saturation
    write_reg(REG_LAMBDA, 32'hFFFF_FFFF);
    write_reg(REG_SLIDING, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_I, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
    write_reg(REG_GAIN_G, 32'h7FFF_FFFF);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LO, 32'h0);
    write_reg(REG_SPARE_HI, 32'h0);
    repeat (4) send_tick(random_tick());
    send_tick({32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF});
    send_tick({5{32'h0001_0000}});
    drain();

    // Directed: zero gains and zero time step freeze the estimates
    write_reg(REG_LAMBDA, 32'h0);
    write_reg(REG_SLIDING, 32'h0);
    write_reg(REG_GAIN_I, 32'h0);
    write_reg(REG_GAIN_D, 32'h0);
    write_reg(REG_GAIN_G, 32'h0);
    write_reg(REG_STEP, 32'h0);
    repeat (4) send_tick(random_tick());
    drain();

    // Random phases with varied gains and idling
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      write_reg(REG_LAMBDA, pick_gain());
      write_reg(REG_SLIDING, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      write_reg(REG_GAIN_G, pick_gain());
      write_reg(REG_STEP, ($urandom_range(3) == 0) ? $urandom() :
                          $urandom_range(0, 42949672));
      repeat (100) begin
        tk = random_tick();
        send_tick(tk);
      end
      if (phase == 2) begin
        // Hold the receiver off while ticks keep being offered
        hold_request = 3000;
        repeat (3) send_tick(random_tick());
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d commands never arrived", sb.expected_q.size());
      sb.errors++;
    end
    $display("covered %0d ticks and %0d commands over 8 gain settings", sb.ticks,
             sb.commands);
    $display("idle mixes: none, sender, receiver, both; one long receiver hold");
    if (sb.errors == 0) begin
      $display("[adaptive_pendulum_controller] OK");
    end else begin
      $display("[adaptive_pendulum_controller] ERROR");
    end
    $finish;
  end

endmodule
